// File: rtl/hsvc_pkg.sv
// Shared types and constants for the HSV color pixel classifier.
// Has no dependencies; the classifier datapath, the register block and the top level import it.
`timescale 1ns / 1ps

package hsvc_pkg;

    // Component and register widths.
    localparam int unsigned CompW   = 8;
    localparam int unsigned ModeW   = 2;
    localparam int unsigned ApbAddrW = 3;
    localparam int unsigned ApbDataW = 32;

    // Register index of the color mode register.
    localparam logic [0:0] RegColorMode = 1'b0;

    // Color selection codes. The fourth code selects no color.
    typedef enum logic [ModeW-1:0] {
        MODE_RED   = 2'd0,
        MODE_GREEN = 2'd1,
        MODE_BLUE  = 2'd2
    } t_color_mode;

    // One RGB pixel.
    typedef struct packed {
        logic [CompW-1:0] red;
        logic [CompW-1:0] green;
        logic [CompW-1:0] blue;
    } t_pixel;

    // Absolute difference of two components.
    function automatic logic [CompW-1:0] abs_diff(input logic [CompW-1:0] a,
                                                  input logic [CompW-1:0] b);
        logic [CompW-1:0] res;
        res = (a >= b) ? (a - b) : (b - a);
        return res;
    endfunction

endpackage

// File: rtl/hsvc_match.sv
// Combinational color test for one pixel: max, min, delta and the threshold compares.
// Depends on hsvc_pkg for the pixel type, the mode codes and abs_diff.
`timescale 1ns / 1ps

module hsvc_match (
    input  hsvc_pkg::t_pixel          i_pixel,
    input  logic [hsvc_pkg::ModeW-1:0] i_mode,
    output logic                       o_mask
);
    import hsvc_pkg::*;

    logic [CompW-1:0] w_r, w_g, w_b;
    logic [CompW-1:0] w_max, w_min, w_delta;
    logic [CompW-1:0] w_max_rg, w_min_rg;
    logic             w_red_max, w_green_max;
    logic             w_red_ok, w_green_ok, w_blue_ok;
    logic [15:0]      w_d100, w_m38;
    logic [10:0]      w_d5;
    logic [11:0]      w_m10;
    logic [9:0]       w_gb2, w_br3, w_d2;
    logic [10:0]      w_br6, w_gr6;
    logic [CompW-1:0] w_b_r, w_g_r;

    assign w_r = i_pixel.red;
    assign w_g = i_pixel.green;
    assign w_b = i_pixel.blue;

    // Maximum, minimum and spread of the three components.
    assign w_max_rg = (w_g > w_r) ? w_g : w_r;
    assign w_min_rg = (w_g < w_r) ? w_g : w_r;
    assign w_max    = (w_b > w_max_rg) ? w_b : w_max_rg;
    assign w_min    = (w_b < w_min_rg) ? w_b : w_min_rg;
    assign w_delta  = w_max - w_min;

    assign w_red_max   = (w_r == w_max);
    assign w_green_max = (w_g == w_max);

    // Scaled terms; every product is a small constant multiply.
    assign w_d100 = 16'(w_delta) * 16'd100;
    assign w_m38  = 16'(w_max) * 16'd38;
    assign w_d5   = 11'(w_delta) * 11'd5;
    assign w_m10  = 12'(w_max) * 12'd10;
    assign w_d2   = {1'b0, w_delta, 1'b0};
    assign w_gb2  = {1'b0, abs_diff(w_g, w_b), 1'b0};
    assign w_br3  = 10'(abs_diff(w_b, w_r)) * 10'd3;
    assign w_b_r  = w_b - w_r;
    assign w_g_r  = w_g - w_r;
    assign w_br6  = 11'(w_b_r) * 11'd6;
    assign w_gr6  = 11'(w_g_r) * 11'd6;

    // Red: red dominant, saturated enough, and hue near zero.
    assign w_red_ok = w_red_max && (w_d100 > w_m38) && (w_gb2 <= {2'b00, w_delta});

    // Green: green dominant over red, saturated, hue near 120 degrees.
    assign w_green_ok = !w_red_max && w_green_max && (w_d5 > 11'(w_max))
                        && (w_br3 <= w_d2);

    // Blue: bright, saturated, and hue in the blue band from either side.
    always_comb begin
        w_blue_ok = 1'b0;
        if ((w_m10 > 12'd765) && (w_d5 > 11'(w_max)) && !w_red_max) begin
            if (w_green_max) begin
                w_blue_ok = (w_b > w_r) && (w_br6 > w_d5);
            end else begin
                w_blue_ok = (w_g > w_r) && (w_gr6 > 11'(w_delta));
            end
        end
    end

    // Mode selection; black and grey pixels never match.
    always_comb begin
        o_mask = 1'b0;
        if ((w_max != '0) && (w_delta != '0)) begin
            case (i_mode)
                MODE_RED:   o_mask = w_red_ok;
                MODE_GREEN: o_mask = w_green_ok;
                MODE_BLUE:  o_mask = w_blue_ok;
                default:    o_mask = 1'b0;
            endcase
        end
    end

endmodule

// File: rtl/hsvc_regs.sv
// APB-style register block holding the color mode register.
// Depends on hsvc_pkg for the bus widths and the register index.
`timescale 1ns / 1ps

module hsvc_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hsvc_pkg::ApbAddrW-1:0] paddr,
    input  logic [hsvc_pkg::ApbDataW-1:0] pwdata,
    output logic [hsvc_pkg::ApbDataW-1:0] prdata,
    output logic                          pready,
    output logic [hsvc_pkg::ModeW-1:0]    o_mode
);
    import hsvc_pkg::*;

    logic [ModeW-1:0] r_mode;
    logic             w_sel_mode;
    logic             w_wr;

    assign pready     = 1'b1;
    assign w_sel_mode = (paddr[ApbAddrW-1] == RegColorMode);
    assign w_wr       = psel && penable && pwrite;

    // The mode register takes the low bits of a write transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ModeW'(MODE_RED);
        end else if (w_wr && w_sel_mode) begin
            r_mode <= pwdata[ModeW-1:0];
        end
    end

    // Read data; addresses with the top address bit set read as zero.
    assign prdata = w_sel_mode ? {{(ApbDataW-ModeW){1'b0}}, r_mode} : '0;
    assign o_mode = r_mode;

endmodule

// File: rtl/hsv_color_pixel_classifier_unit.sv
// Top level of the HSV color pixel classifier: input register, classifier, result register.
// Depends on hsvc_pkg, hsvc_regs and hsvc_match.
`timescale 1ns / 1ps

// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+------------------------------------
// pixel     | in        | start high, busy low       | i_red, i_green, i_blue, i_last_in_frame
// result    | out       | o_done strobe, one cycle   | o_mask, o_frame_end
// config    | in/out    | APB psel/penable/pready    | paddr, pwdata, prdata
//
// One pixel transaction is accepted per clock while busy is low; its result is registered
// first in the input register, then in the result register around the classifier logic.
// busy is high only during reset and the cycle after it; nothing else stops the pipeline.
// Reset is synchronous and clears the valid bits and the mode register.
// The receiver cannot stall, so every result is presented for exactly one cycle.

module hsv_color_pixel_classifier_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [hsvc_pkg::CompW-1:0]    i_red,
    input  logic [hsvc_pkg::CompW-1:0]    i_green,
    input  logic [hsvc_pkg::CompW-1:0]    i_blue,
    input  logic                          i_last_in_frame,
    output logic                          o_done,
    output logic                          o_mask,
    output logic                          o_frame_end,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hsvc_pkg::ApbAddrW-1:0] paddr,
    input  logic [hsvc_pkg::ApbDataW-1:0] pwdata,
    output logic [hsvc_pkg::ApbDataW-1:0] prdata,
    output logic                          pready
);
    import hsvc_pkg::*;

    logic             r_busy;
    logic             r_in_valid;
    t_pixel           r_in_pixel;
    logic             r_in_last;
    logic             r_done;
    logic             r_mask;
    logic             r_frame_end;
    logic             w_accept;
    logic             w_mask;
    logic [ModeW-1:0] w_mode;

    // Configuration registers.
    hsvc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_mode  (w_mode)
    );

    // Busy covers reset and the first cycle out of it.
    always_ff @(posedge i_clk) begin
        r_busy <= !i_rst_n;
    end
    assign busy     = r_busy || !i_rst_n;
    assign w_accept = start && !busy;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_pixel <= '{red: i_red, green: i_green, blue: i_blue};
            r_in_last  <= i_last_in_frame;
        end
    end

    // Classifier logic between the two registers.
    hsvc_match u_match (
        .i_pixel (r_in_pixel),
        .i_mode  (w_mode),
        .o_mask  (w_mask)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_mask      <= w_mask;
            r_frame_end <= r_in_last;
        end
    end

    assign o_done      = r_done;
    assign o_mask      = r_mask;
    assign o_frame_end = r_frame_end;

    // Every accepted transaction strobes its result after the input and result registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ##1 o_done)
        else $error("accepted pixel produced no result strobe");

    // A result strobe always traces back to a valid input register.
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_in_valid))
        else $error("result strobe without a registered pixel");

    // A grey pixel never produces a match.
    a_grey_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_mask) |-> $past((r_in_pixel.red != r_in_pixel.green)
                                     || (r_in_pixel.green != r_in_pixel.blue)))
        else $error("grey pixel reported as a color match");

endmodule
